// ===== design/mlcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcf_pkg
// shared types and constants of the midi learned-control filter
// ----------------------------------------------------------------------------
package mlcf_pkg;

  localparam int NUM_CHANNELS     = 16;
  localparam int KEYS_PER_CHANNEL = 128;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ROW_W = (KEYS_PER_CHANNEL > 1) ? $clog2(KEYS_PER_CHANNEL) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] THRESHOLD_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSPECT = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_BIND    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MSG_NOTE_OFF = 2'd0,
    MSG_NOTE_ON  = 2'd1,
    MSG_CC       = 2'd2,
    MSG_OTHER    = 2'd3
  } msg_t;

  typedef enum logic [1:0] {
    VD_PLAY    = 2'd0,
    VD_SWALLOW = 2'd1,
    VD_CAPTURE = 2'd2,
    VD_FIRE    = 2'd3
  } verdict_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_t;

  // one classified item as it waits in the queue
  typedef struct packed {
    cmd_t              cmd;
    logic              is_note;
    logic              is_cc;
    logic              note_off;
    logic              actuation;
    logic              armed;
    logic              bind_ctrl;
    logic              bind_all;
    logic              ch_ok;
    logic              key_ok;
    logic [CH_W-1:0]   ch;
    logic [ROW_W-1:0]  row;
  } mlcf_item_t;

endpackage

// ===== design/midi_learned_control_filter_core.sv =====
// ----------------------------------------------------------------------------
// midi_learned_control_filter_core
// filters midi events against learned note and controller bindings
// ----------------------------------------------------------------------------
// flow: an inspect verdict passes from its queue entry through the row read
// registers to the registered result strobe, and it waits behind earlier items
// in the queue; the back end takes a new item once the last key row is updated
// busy rises when the two-entry queue is full; results cannot be stalled
// reset: tables read as cleared at once through per-row flags, no clearing
// pass; controller threshold returns to 64
module midi_learned_control_filter_core
  import mlcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_message_type,
  input  logic [3:0]  in_channel,
  input  logic [6:0]  in_key_or_controller,
  input  logic [6:0]  in_value_byte,
  input  logic        in_learn_armed,
  input  logic        in_bind_is_controller,
  input  logic        in_bind_all_channels,
  output logic        out_strobe,
  output logic [1:0]  out_verdict,
  input  logic        cfg_write_en,
  input  logic [6:0]  cfg_write_data
);

  logic [6:0]   threshold_r;
  logic         q_valid, q_pop;
  mlcf_item_t   q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_write_en) begin
      threshold_r <= cfg_write_data;
    end
  end

  mlcf_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_message_type       (in_message_type),
    .in_channel            (in_channel),
    .in_key_or_controller  (in_key_or_controller),
    .in_value_byte         (in_value_byte),
    .in_learn_armed        (in_learn_armed),
    .in_bind_is_controller (in_bind_is_controller),
    .in_bind_all_channels  (in_bind_all_channels),
    .threshold             (threshold_r),
    .q_pop                 (q_pop),
    .q_valid               (q_valid),
    .q_item                (q_item)
  );

  mlcf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_strobe  (out_strobe),
    .out_verdict (out_verdict)
  );

endmodule

// ===== design/mlcf_front.sv =====
// ----------------------------------------------------------------------------
// mlcf_front
// accepts commands, classifies the event and queues it for the back end
// ----------------------------------------------------------------------------
module mlcf_front
  import mlcf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_command,
  input  logic [1:0]       in_message_type,
  input  logic [3:0]       in_channel,
  input  logic [6:0]       in_key_or_controller,
  input  logic [6:0]       in_value_byte,
  input  logic             in_learn_armed,
  input  logic             in_bind_is_controller,
  input  logic             in_bind_all_channels,
  input  logic [6:0]       threshold,
  input  logic             q_pop,
  output logic             q_valid,
  output mlcf_item_t       q_item
);

  mlcf_item_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;
  mlcf_item_t              cls;
  msg_t                    msg;
  logic                    push;

  assign busy    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // unused command code is dropped here
  assign push = start && !busy && (cmd_t'(in_command) != CMD_NOP);

  always_comb begin
    msg           = msg_t'(in_message_type);
    cls.cmd       = cmd_t'(in_command);
    // note-on at zero velocity counts as note-off
    cls.note_off  = (msg == MSG_NOTE_OFF) || ((msg == MSG_NOTE_ON) && (in_value_byte == 7'd0));
    cls.is_note   = (msg == MSG_NOTE_ON);
    cls.is_cc     = (msg == MSG_CC);
    cls.actuation = ((msg == MSG_NOTE_ON) && (in_value_byte != 7'd0)) ||
                    ((msg == MSG_CC) && (in_value_byte >= threshold));
    cls.armed     = in_learn_armed;
    cls.bind_ctrl = in_bind_is_controller;
    cls.bind_all  = in_bind_all_channels;
    cls.ch_ok     = (32'(in_channel) < NUM_CHANNELS);
    cls.key_ok    = (32'(in_key_or_controller) < KEYS_PER_CHANNEL);
    cls.ch        = CH_W'(in_channel);
    cls.row       = ROW_W'(in_key_or_controller);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/mlcf_back.sv =====
// ----------------------------------------------------------------------------
// mlcf_back
// executes queued items against the binding and swallowed-note tables
// ----------------------------------------------------------------------------
module mlcf_back
  import mlcf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mlcf_item_t       q_item,
  output logic             q_pop,
  output logic             out_strobe,
  output logic [1:0]       out_verdict
);

  localparam int NCH = NUM_CHANNELS;

  // tables stored one row per key, one bit per channel; bindings keep
  // controller bits above note bits
  logic [2*NCH-1:0]          bind_mem [KEYS_PER_CHANNEL];
  logic [NCH-1:0]            swal_mem [KEYS_PER_CHANNEL];
  logic [KEYS_PER_CHANNEL-1:0] bind_vld_r;
  logic [KEYS_PER_CHANNEL-1:0] swal_vld_r;
  logic [2*NCH-1:0]          bind_rd_r;
  logic [NCH-1:0]            swal_rd_r;

  back_state_t               state_r, state_nxt;
  mlcf_item_t                cur_r;
  logic                      exec;

  logic [2*NCH-1:0]          bind_row;
  logic [NCH-1:0]            note_row, ctrl_row, swal_row, swal_new, ch_onehot, bind_mask;
  logic [2*NCH-1:0]          bind_new;
  logic                      loc_ok, note_b, ctrl_b, swal_b, bound;
  logic                      bind_we, swal_we, clear_all, res_valid;
  verdict_t                  verdict;

  logic                      out_strobe_r;
  logic [1:0]                out_verdict_r;

  assign out_strobe  = out_strobe_r;
  assign out_verdict = out_verdict_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop = 1'b0;
    exec  = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_EXEC: exec  = 1'b1;
      default: ;
    endcase
  end

  // row read while the item is popped, used in the execute cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      bind_rd_r <= bind_mem[q_item.row];
      swal_rd_r <= swal_mem[q_item.row];
      cur_r     <= q_item;
    end
  end

  always_comb begin
    bind_row  = bind_vld_r[cur_r.row] ? bind_rd_r : '0;
    swal_row  = swal_vld_r[cur_r.row] ? swal_rd_r : '0;
    note_row  = bind_row[NCH-1:0];
    ctrl_row  = bind_row[2*NCH-1:NCH];
    loc_ok    = cur_r.key_ok && cur_r.ch_ok;
    ch_onehot = NCH'(1) << cur_r.ch;
    note_b    = loc_ok && ((note_row & ch_onehot) != '0);
    ctrl_b    = loc_ok && ((ctrl_row & ch_onehot) != '0);
    swal_b    = loc_ok && ((swal_row & ch_onehot) != '0);
    bound     = (cur_r.is_note && note_b) || (cur_r.is_cc && ctrl_b);

    verdict   = VD_PLAY;
    swal_new  = swal_row;
    swal_we   = 1'b0;
    bind_we   = 1'b0;
    clear_all = 1'b0;
    res_valid = 1'b0;
    bind_mask = cur_r.bind_all ? {NCH{1'b1}} : (cur_r.ch_ok ? ch_onehot : '0);
    bind_new  = cur_r.bind_ctrl ? (bind_row | {bind_mask, NCH'(0)})
                                : (bind_row | {NCH'(0), bind_mask});

    if (exec) begin
      unique case (cur_r.cmd)
        CMD_INSPECT: begin
          res_valid = 1'b1;
          priority if (cur_r.note_off) begin
            if (swal_b) begin
              verdict  = VD_SWALLOW;
              swal_new = swal_row & ~ch_onehot;
              swal_we  = 1'b1;
            end
          end else if (cur_r.armed && cur_r.actuation) begin
            verdict = VD_CAPTURE;
            if (cur_r.is_note && loc_ok) begin
              swal_new = swal_row | ch_onehot;
              swal_we  = 1'b1;
            end
          end else if (!bound) begin
            verdict = VD_PLAY;
          end else if (!cur_r.actuation) begin
            verdict = VD_SWALLOW;
          end else begin
            verdict = VD_FIRE;
            if (cur_r.is_note) begin
              swal_new = swal_row | ch_onehot;
              swal_we  = 1'b1;
            end
          end
        end
        CMD_CLEAR: clear_all = 1'b1;
        CMD_BIND:  bind_we   = cur_r.key_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (bind_we) begin
      bind_mem[cur_r.row] <= bind_new;
    end
    if (swal_we) begin
      swal_mem[cur_r.row] <= swal_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      bind_vld_r    <= '0;
      swal_vld_r    <= '0;
      out_strobe_r  <= 1'b0;
      out_verdict_r <= VD_PLAY;
    end else begin
      state_r       <= state_nxt;
      out_strobe_r  <= res_valid;
      out_verdict_r <= verdict;
      // clearing bindings only drops the row flags, swallowed marks survive
      if (clear_all) begin
        bind_vld_r <= '0;
      end else if (bind_we) begin
        bind_vld_r[cur_r.row] <= 1'b1;
      end
      if (swal_we) begin
        swal_vld_r[cur_r.row] <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/tb_midi_learned_control_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_midi_learned_control_filter_core
// self-checking bench for the midi learned-control filter: a queue-fed driver
// issues inspect, clear, bind and nop items with random gaps, a local predictor
// keeps its own binding and swallow tables, and every strobed verdict is
// checked in order against the predicted one
// ----------------------------------------------------------------------------
module tb_midi_learned_control_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mlcf_pkg::*;

  localparam int TABLE_N        = NUM_CHANNELS * KEYS_PER_CHANNEL;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_ITEMS    = 340;
  localparam int NUM_PHASES     = 5;

  typedef struct {
    cmd_t       cmd;
    msg_t       msg;
    logic [3:0] ch;
    logic [6:0] key;
    logic [6:0] val;
    logic       armed;
    logic       bind_ctl;
    logic       bind_all;
    int         gap;
  } evt_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_command = '0;
  logic [1:0] in_message_type = '0;
  logic [3:0] in_channel = '0;
  logic [6:0] in_key_or_controller = '0;
  logic [6:0] in_value_byte = '0;
  logic       in_learn_armed = 1'b0;
  logic       in_bind_is_controller = 1'b0;
  logic       in_bind_all_channels = 1'b0;
  logic       out_strobe;
  logic [1:0] out_verdict;
  logic       cfg_write_en = 1'b0;
  logic [6:0] cfg_write_data = '0;

  // predictor state
  logic       note_bind_map [0:TABLE_N-1];
  logic       cc_bind_map   [0:TABLE_N-1];
  logic       swallow_map   [0:TABLE_N-1];
  logic [6:0] thr_model;

  evt_item_t  pending_q [$];
  verdict_t   verdict_q [$];
  evt_item_t  cur_item;
  bit         item_loaded = 1'b0;
  int         hold_left = 0;
  bit         took_item = 1'b0;
  int         cycle_count = 0;
  int         mismatch_count = 0;
  int         gap_max = 9;
  logic [6:0] thr_now = THRESHOLD_RESET;

  midi_learned_control_filter_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_message_type       (in_message_type),
    .in_channel            (in_channel),
    .in_key_or_controller  (in_key_or_controller),
    .in_value_byte         (in_value_byte),
    .in_learn_armed        (in_learn_armed),
    .in_bind_is_controller (in_bind_is_controller),
    .in_bind_all_channels  (in_bind_all_channels),
    .out_strobe            (out_strobe),
    .out_verdict           (out_verdict),
    .cfg_write_en          (cfg_write_en),
    .cfg_write_data        (cfg_write_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // works out the verdict of one accepted item and updates the local tables
  function automatic bit predict_verdict(input evt_item_t it, output verdict_t vd);
    bit hit;
    bit note_off;
    bit actuation;
    bit bound;
    int slot;
    int idx;
    vd = VD_PLAY;
    hit = (int'(it.ch) < NUM_CHANNELS) && (int'(it.key) < KEYS_PER_CHANNEL);
    slot = hit ? int'(it.ch) * KEYS_PER_CHANNEL + int'(it.key) : 0;
    case (it.cmd)
      CMD_CLEAR: begin
        // swallow marks are kept on purpose
        for (int i = 0; i < TABLE_N; i++) begin
          note_bind_map[i] = 1'b0;
          cc_bind_map[i]   = 1'b0;
        end
        return 1'b0;
      end
      CMD_BIND: begin
        if (it.bind_all) begin
          if (int'(it.key) < KEYS_PER_CHANNEL) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
              idx = c * KEYS_PER_CHANNEL + int'(it.key);
              if (it.bind_ctl) cc_bind_map[idx] = 1'b1;
              else note_bind_map[idx] = 1'b1;
            end
          end
        end else if (hit) begin
          if (it.bind_ctl) cc_bind_map[slot] = 1'b1;
          else note_bind_map[slot] = 1'b1;
        end
        return 1'b0;
      end
      CMD_INSPECT: begin
        note_off = (it.msg == MSG_NOTE_OFF) || (it.msg == MSG_NOTE_ON && it.val == 7'd0);
        if (note_off) begin
          if (hit && swallow_map[slot]) begin
            swallow_map[slot] = 1'b0;
            vd = VD_SWALLOW;
          end
          return 1'b1;
        end
        actuation = (it.msg == MSG_NOTE_ON && it.val != 7'd0) ||
                    (it.msg == MSG_CC && it.val >= thr_model);
        if (it.armed && actuation) begin
          if (it.msg == MSG_NOTE_ON && hit) swallow_map[slot] = 1'b1;
          vd = VD_CAPTURE;
          return 1'b1;
        end
        bound = hit && ((it.msg == MSG_NOTE_ON && note_bind_map[slot]) ||
                        (it.msg == MSG_CC && cc_bind_map[slot]));
        if (!bound) begin
          vd = VD_PLAY;
        end else if (!actuation) begin
          vd = VD_SWALLOW;
        end else begin
          if (it.msg == MSG_NOTE_ON) swallow_map[slot] = 1'b1;
          vd = VD_FIRE;
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // driver: one item on the bus at a time, start held until taken
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (start && took_item) begin
        nxt_start = 1'b0;
        took_item = 1'b0;
      end
      if (!nxt_start) begin
        if (!item_loaded && pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          item_loaded = 1'b1;
          hold_left = cur_item.gap;
        end
        if (item_loaded) begin
          if (hold_left == 0) begin
            in_command            <= cur_item.cmd;
            in_message_type       <= cur_item.msg;
            in_channel            <= cur_item.ch;
            in_key_or_controller  <= cur_item.key;
            in_value_byte         <= cur_item.val;
            in_learn_armed        <= cur_item.armed;
            in_bind_is_controller <= cur_item.bind_ctl;
            in_bind_all_channels  <= cur_item.bind_all;
            nxt_start = 1'b1;
            item_loaded = 1'b0;
          end else begin
            hold_left--;
          end
        end
      end
    end
    start <= nxt_start;
  end

  // monitor: checks strobed verdicts and predicts each accepted item
  always @(posedge clk) begin
    evt_item_t seen;
    verdict_t  want;
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst_n) begin
      for (int i = 0; i < TABLE_N; i++) begin
        note_bind_map[i] = 1'b0;
        cc_bind_map[i]   = 1'b0;
        swallow_map[i]   = 1'b0;
      end
      thr_model = THRESHOLD_RESET;
    end else begin
      if (cfg_write_en) thr_model = cfg_write_data;
      if (out_strobe === 1'b1) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %0d with nothing expected", out_verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want)
            flag_mismatch($sformatf("verdict %0d, expected %s", out_verdict, want.name()));
        end
      end
      if (start && !busy) begin
        seen.cmd      = cmd_t'(in_command);
        seen.msg      = msg_t'(in_message_type);
        seen.ch       = in_channel;
        seen.key      = in_key_or_controller;
        seen.val      = in_value_byte;
        seen.armed    = in_learn_armed;
        seen.bind_ctl = in_bind_is_controller;
        seen.bind_all = in_bind_all_channels;
        seen.gap      = 0;
        if (predict_verdict(seen, want)) verdict_q.push_back(want);
        took_item = 1'b1;
      end
    end
  end

  task automatic queue_item(input cmd_t cmd, input msg_t msg, input int ch, input int key,
                            input int val, input bit armed, input bit bind_ctl,
                            input bit bind_all);
    evt_item_t it;
    it.cmd      = cmd;
    it.msg      = msg;
    it.ch       = 4'(ch);
    it.key      = 7'(key);
    it.val      = 7'(val);
    it.armed    = armed;
    it.bind_ctl = bind_ctl;
    it.bind_all = bind_all;
    it.gap      = $urandom_range(0, gap_max);
    pending_q.push_back(it);
  endtask

  // keys and channels mostly from a small pool so bindings and marks get hit
  task automatic queue_random_item();
    evt_item_t it;
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 2) it.cmd = CMD_CLEAR;
    else if (r < 4) it.cmd = CMD_NOP;
    else if (r < 14) it.cmd = CMD_BIND;
    else it.cmd = CMD_INSPECT;
    r = $urandom_range(0, 99);
    if (r < 40) it.msg = MSG_NOTE_ON;
    else if (r < 65) it.msg = MSG_NOTE_OFF;
    else if (r < 93) it.msg = MSG_CC;
    else it.msg = MSG_OTHER;
    if ($urandom_range(0, 4) == 0) begin
      it.ch  = 4'($urandom);
      it.key = 7'($urandom);
    end else begin
      it.ch = 4'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) it.key = 7'($urandom_range(0, 5));
      else it.key = 7'(127 - $urandom_range(0, 5));
    end
    case ($urandom_range(0, 5))
      0: it.val = 7'd0;
      1: it.val = 7'd127;
      2: begin
        t = int'(thr_now) + int'($urandom_range(0, 2)) - 1;
        if (t < 0) t = 0;
        if (t > 127) t = 127;
        it.val = 7'(t);
      end
      default: it.val = 7'($urandom);
    endcase
    it.armed    = ($urandom_range(0, 4) == 0);
    it.bind_ctl = 1'($urandom);
    it.bind_all = ($urandom_range(0, 3) == 0);
    it.gap      = $urandom_range(0, gap_max);
    pending_q.push_back(it);
  endtask

  // sender holds off until every item has gone and every verdict has come
  task automatic wait_quiet();
    do begin
      @(posedge clk);
    end while (pending_q.size() != 0 || item_loaded || start || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [6:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    thr_now = value;
  endtask

  initial begin
    logic [6:0] phase_thr [NUM_PHASES];
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, threshold at its reset value
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  0,   0, 127, 0, 0, 0);
    queue_item(CMD_BIND,    MSG_OTHER,    0,   0, 127, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  0,   0, 127, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_OFF, 0,   0,   0, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_OFF, 0,   0,   0, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  0,   0,   1, 0, 0, 0);
    // note-on with zero velocity releases the mark like a note-off
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  0,   0,   0, 0, 0, 0);
    queue_item(CMD_BIND,    MSG_NOTE_ON,  5, 127,  33, 0, 1, 1);
    queue_item(CMD_INSPECT, MSG_CC,      15, 127,  64, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_CC,      15, 127,  63, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_CC,       0, 127, 127, 0, 1, 1);
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  3,   5, 100, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_OFF, 3,   5,   0, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_CC,       9,  10, 127, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_CC,       9,  10,   0, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_OTHER,   15, 127, 127, 1, 1, 1);
    queue_item(CMD_INSPECT, MSG_NOTE_ON,  0,   0, 127, 0, 0, 0);
    queue_item(CMD_CLEAR,   MSG_CC,      15, 127, 127, 1, 1, 1);
    queue_item(CMD_NOP,     MSG_NOTE_ON,  0,   0, 127, 1, 1, 1);
    queue_item(CMD_INSPECT, MSG_NOTE_OFF, 0,   0,   0, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_CC,      15, 127, 127, 0, 0, 0);
    queue_item(CMD_BIND,    MSG_CC,      15, 127,   0, 0, 0, 0);
    // armed capture wins over a bound fire
    queue_item(CMD_INSPECT, MSG_NOTE_ON, 15, 127, 127, 1, 0, 0);
    queue_item(CMD_INSPECT, MSG_NOTE_OFF, 15, 127,  0, 0, 0, 0);
    queue_item(CMD_INSPECT, MSG_OTHER,    0,   0,   0, 0, 0, 0);

    phase_thr[0] = 7'd0;
    phase_thr[1] = 7'd127;
    phase_thr[2] = 7'($urandom);
    phase_thr[3] = 7'($urandom);
    phase_thr[4] = THRESHOLD_RESET;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_threshold(phase_thr[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // blocks of back-to-back items between blocks with random gaps
        if (i % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        queue_random_item();
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
